// File: design/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types for the sparse triplet accumulator: result status codes and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sta_pkg;

   typedef enum logic [1:0] {
      STATUS_MERGED   = 2'd0,
      STATUS_APPENDED = 2'd1,
      STATUS_DROPPED  = 2'd2,
      STATUS_CLEARED  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      logic       load_item;
      logic       rd_issue;
      logic       finish;
      status_type kind;
   } sta_cmd_type;

   typedef struct packed {
      logic item_clear;
      logic all_issued;
      logic rd_vld;
      logic match;
      logic full;
   } sta_stat_type;

endpackage

// File: design/sparse_triplet_accumulator.sv
// An add item that matches slot k ends its search at slot k; a miss (append
// or drop) reads every stored entry first, and a clear does no search.
// Throughput: one item at a time, set by the linear search that reads one
// stored entry per cycle through the single registered memory read port.
// Reset empties the table (fill count zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
// sparse_triplet_accumulator
// Coordinate-form sparse matrix assembly: merges or appends triplets into a
// table of up to CAPACITY entries with saturating Q16.16 accumulation.
// ----------------------------------------------------------------------------
module sparse_triplet_accumulator
   import sta_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int INDEX_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [15:0]        req_col,
   input  logic [15:0]        req_row,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_slot,
   output logic [10:0]        rsp_entry_count,
   output logic signed [31:0] rsp_sum
);

   sta_cmd_type  cmd;
   sta_stat_type stat;

   sta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sta_datapath #(
      .CAPACITY   (CAPACITY),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_op),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_count (rsp_entry_count),
      .rsp_sum         (rsp_sum)
   );

endmodule

// File: design/sta_ctrl.sv
// ----------------------------------------------------------------------------
// sta_ctrl
// Controller for the accumulator: takes an item, runs the search over the
// stored entries, and commits the outcome once the result register is free.
// ----------------------------------------------------------------------------
module sta_ctrl
   import sta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  sta_stat_type stat,
   output sta_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type  state_ff;
   status_type kind_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.kind      = kind_ff;
      cmd.load_item = (state_ff == ST_IDLE) && req_valid;
      // Reads stop as soon as a match is seen, so the read register keeps
      // the matching entry until it is committed.
      cmd.rd_issue  = (state_ff == ST_SEARCH) && !stat.item_clear &&
                      !stat.all_issued && !stat.match;
      cmd.finish    = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= STATUS_MERGED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (stat.item_clear) begin
                  kind_ff  <= STATUS_CLEARED;
                  state_ff <= ST_FINISH;
               end else if (stat.match) begin
                  kind_ff  <= STATUS_MERGED;
                  state_ff <= ST_FINISH;
               end else if (stat.all_issued && !stat.rd_vld) begin
                  kind_ff  <= stat.full ? STATUS_DROPPED : STATUS_APPENDED;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: design/sta_datapath.sv
// ----------------------------------------------------------------------------
// sta_datapath
// Entry memory, fill count, search counter with a registered read port,
// coordinate compare, saturating Q16.16 adder and the result registers.
// ----------------------------------------------------------------------------
module sta_datapath
   import sta_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int INDEX_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  sta_cmd_type        cmd,
   output sta_stat_type       stat,
   input  logic               req_op,
   input  logic [15:0]        req_col,
   input  logic [15:0]        req_row,
   input  logic signed [31:0] req_value,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_slot,
   output logic [10:0]        rsp_entry_count,
   output logic signed [31:0] rsp_sum
);

   localparam int CW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int EW = 2 * CW + 32;

   logic [EW-1:0] mem [CAPACITY];

   logic          item_op_ff;
   logic [CW-1:0] item_col_ff;
   logic [CW-1:0] item_row_ff;
   logic [31:0]   item_value_ff;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] idx_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [EW-1:0] rd_data_ff;
   logic [1:0]    rsp_status_ff;
   logic [9:0]    rsp_slot_ff;
   logic [10:0]   rsp_entry_count_ff;
   logic [31:0]   rsp_sum_ff;

   logic [CW-1:0] rd_col;
   logic [CW-1:0] rd_row;
   logic [31:0]   rd_value;
   logic [32:0]   sum_wide;
   logic [31:0]   merged;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [31:0]   slot_wide;
   logic [31:0]   fill_wide;
   logic [31:0]   fill_inc_wide;

   // Entry layout: column, row, value from the top down.
   assign rd_col   = rd_data_ff[EW-1 -: CW];
   assign rd_row   = rd_data_ff[32 +: CW];
   assign rd_value = rd_data_ff[31:0];

   assign stat.item_clear = (item_op_ff == OP_CLEAR);
   assign stat.all_issued = (idx_ff == fill_ff);
   assign stat.rd_vld     = rd_vld_ff;
   assign stat.match      = rd_vld_ff && (rd_col == item_col_ff) &&
                            (rd_row == item_row_ff);
   assign stat.full       = (fill_ff == FW'(CAPACITY));

   // A sign change between the two top bits of the wide sum is an overflow.
   assign sum_wide = {rd_value[31], rd_value} + {item_value_ff[31], item_value_ff};
   always_comb begin
      if (sum_wide[32] != sum_wide[31]) begin
         merged = sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         merged = sum_wide[31:0];
      end
   end

   assign wr_en   = cmd.finish &&
                    (cmd.kind == STATUS_MERGED || cmd.kind == STATUS_APPENDED);
   assign wr_addr = (cmd.kind == STATUS_MERGED) ? rd_idx_ff : fill_ff[AW-1:0];
   assign wr_data = {item_col_ff, item_row_ff,
                     (cmd.kind == STATUS_MERGED) ? merged : item_value_ff};

   assign slot_wide     = 32'(rd_idx_ff);
   assign fill_wide     = 32'(fill_ff);
   assign fill_inc_wide = fill_wide + 32'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
         rd_idx_ff  <= idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_op_ff    <= req_op;
         item_col_ff   <= req_col[CW-1:0];
         item_row_ff   <= req_row[CW-1:0];
         item_value_ff <= req_value;
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.kind;
         case (cmd.kind)
            STATUS_MERGED: begin
               rsp_slot_ff        <= slot_wide[9:0];
               rsp_entry_count_ff <= fill_wide[10:0];
               rsp_sum_ff         <= merged;
            end
            STATUS_APPENDED: begin
               rsp_slot_ff        <= fill_wide[9:0];
               rsp_entry_count_ff <= fill_inc_wide[10:0];
               rsp_sum_ff         <= item_value_ff;
            end
            STATUS_DROPPED: begin
               rsp_slot_ff        <= '0;
               rsp_entry_count_ff <= fill_wide[10:0];
               rsp_sum_ff         <= '0;
            end
            default: begin
               rsp_slot_ff        <= '0;
               rsp_entry_count_ff <= '0;
               rsp_sum_ff         <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
         end else begin
            rd_vld_ff <= cmd.rd_issue;
            if (cmd.rd_issue) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            if (cmd.kind == STATUS_CLEARED) begin
               fill_ff <= '0;
            end else if (cmd.kind == STATUS_APPENDED) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_sum         = rsp_sum_ff;

endmodule

// File: design/sta_checker.sv
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks for the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module sta_checker
   import sta_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [9:0]         rsp_slot,
   input logic [10:0]        rsp_entry_count,
   input logic signed [31:0] rsp_sum
);

   // A stalled result must hold until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot) && $stable(rsp_entry_count) && $stable(rsp_sum))
      else $error("result changed while stalled");

   // Only one item is in flight, so the input closes right after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after an item was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CLEARED |->
      rsp_slot == '0 && rsp_entry_count == '0 && rsp_sum == '0)
      else $error("clear result not empty");

   // A dropped item only happens on a full table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DROPPED |->
      rsp_slot == '0 && rsp_sum == '0 && rsp_entry_count == 11'(CAPACITY))
      else $error("drop reported on a table that is not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_APPENDED |->
      rsp_entry_count[9:0] == rsp_slot + 10'd1)
      else $error("append count does not follow its slot");

endmodule

bind sparse_triplet_accumulator sta_checker #(.CAPACITY(CAPACITY)) u_sta_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_entry_count (rsp_entry_count),
   .rsp_sum         (rsp_sum)
);

// File: bench/tb_sparse_triplet_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_triplet_accumulator
// Drives add and clear items through the valid/ready request channel, keeps
// its own copy of the coordinate table to predict each result, and checks
// every result field against that prediction under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_accumulator;
   import sta_pkg::*;

   localparam int CAPACITY       = 1024;
   localparam int INDEX_BITS     = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam longint SUM_MAX    = 64'sd2147483647;
   localparam longint SUM_MIN    = -64'sd2147483648;

   typedef struct {
      status_type         status;
      logic [9:0]         slot;
      logic [10:0]        entry_count;
      logic signed [31:0] sum;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = 1'b0;
   logic [15:0]        req_col = '0;
   logic [15:0]        req_row = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [9:0]         rsp_slot;
   logic [10:0]        rsp_entry_count;
   logic signed [31:0] rsp_sum;

   // Model of the coordinate table.
   logic [15:0]        table_col [CAPACITY];
   logic [15:0]        table_row [CAPACITY];
   logic signed [31:0] table_sum [CAPACITY];
   int                 table_fill = 0;

   outcome_type pending_results [$];
   int          error_count   = 0;
   int          stall_cycles  = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   sparse_triplet_accumulator #(
      .CAPACITY   (CAPACITY),
      .INDEX_BITS (INDEX_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_count (rsp_entry_count),
      .rsp_sum         (rsp_sum)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic signed [31:0] saturate_sum(logic signed [31:0] a,
                                                       logic signed [31:0] b);
      longint total;
      total = longint'(a) + longint'(b);
      if (total > SUM_MAX) return SUM_MAX[31:0];
      if (total < SUM_MIN) return SUM_MIN[31:0];
      return total[31:0];
   endfunction

   // Applies one item to the table model and returns the result it yields.
   function automatic outcome_type apply_triplet(op_type op, logic [15:0] col,
                                                 logic [15:0] row,
                                                 logic signed [31:0] value);
      outcome_type res;
      res.status      = STATUS_CLEARED;
      res.slot        = '0;
      res.entry_count = '0;
      res.sum         = '0;
      if (op == OP_CLEAR) begin
         table_fill = 0;
         return res;
      end
      for (int idx = 0; idx < table_fill; idx++) begin
         if (table_col[idx] == col && table_row[idx] == row) begin
            table_sum[idx]  = saturate_sum(table_sum[idx], value);
            res.status      = STATUS_MERGED;
            res.slot        = idx[9:0];
            res.entry_count = table_fill[10:0];
            res.sum         = table_sum[idx];
            return res;
         end
      end
      if (table_fill >= CAPACITY) begin
         res.status      = STATUS_DROPPED;
         res.entry_count = table_fill[10:0];
         return res;
      end
      table_col[table_fill] = col;
      table_row[table_fill] = row;
      table_sum[table_fill] = value;
      res.status      = STATUS_APPENDED;
      res.slot        = table_fill[9:0];
      table_fill++;
      res.entry_count = table_fill[10:0];
      res.sum         = value;
      return res;
   endfunction

   // Presents one item and returns at the edge where it is accepted. Valid is
   // left high so that the next call can follow on without a gap.
   task automatic send_triplet(input op_type op, input logic [15:0] col,
                               input logic [15:0] row,
                               input logic signed [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_col   <= col;
      req_row   <= row;
      req_value <= value;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_results.push_back(apply_triplet(op, col, row, value));
   endtask

   task automatic test_directed_corners();
      send_triplet(OP_CLEAR, 16'hFFFF, 16'hFFFF, -32'sd1);
      send_triplet(OP_ADD, 16'h0000, 16'h0000, 32'sh7FFFFFFF);
      send_triplet(OP_ADD, 16'h0000, 16'h0000, 32'sd1);
      send_triplet(OP_ADD, 16'hFFFF, 16'hFFFF, 32'sh80000000);
      send_triplet(OP_ADD, 16'hFFFF, 16'hFFFF, -32'sd1);
      send_triplet(OP_ADD, 16'h0000, 16'hFFFF, 32'sh00018000);
      send_triplet(OP_ADD, 16'hFFFF, 16'h0000, -32'sh00018000);
      send_triplet(OP_ADD, 16'h0000, 16'hFFFF, -32'sh00018000);
      send_triplet(OP_ADD, 16'hFFFF, 16'h0000, 32'sh7FFFFFFF);
      send_triplet(OP_ADD, 16'h0000, 16'h0000, 32'sh80000000);
      send_triplet(OP_ADD, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF);
      send_triplet(OP_ADD, 16'h5555, 16'hAAAA, 32'sh55555555);
      send_triplet(OP_ADD, 16'hAAAA, 16'h5555, 32'shAAAAAAAA);
      send_triplet(OP_ADD, 16'h5555, 16'hAAAA, 32'sh55555555);
      send_triplet(OP_ADD, 16'hAAAA, 16'h5555, 32'shAAAAAAAA);
      send_triplet(OP_CLEAR, 16'h0000, 16'h0000, 32'sd0);
      // After a clear the old entries must no longer be matched.
      send_triplet(OP_ADD, 16'h0000, 16'h0000, 32'sd0);
      send_triplet(OP_ADD, 16'hAAAA, 16'h5555, 32'sh00010000);
   endtask

   // Mostly coordinates from a small pool near both ends of the index range,
   // so that merges are common, with occasional clears keeping the table short.
   task automatic test_random_triplets(input int item_total);
      logic [15:0]        col;
      logic [15:0]        row;
      logic signed [31:0] value;
      for (int n = 0; n < item_total; n++) begin
         if ($urandom_range(99) < 3) begin
            send_triplet(OP_CLEAR, 16'($urandom), 16'($urandom), 32'($urandom));
            continue;
         end
         if ($urandom_range(3) == 0) begin
            col = 16'($urandom);
            row = 16'($urandom);
         end else begin
            col = ($urandom_range(1) ? 16'hFFF8 : 16'h0000) | 16'($urandom_range(7));
            row = ($urandom_range(1) ? 16'hFFF8 : 16'h0000) | 16'($urandom_range(7));
         end
         case ($urandom_range(3))
            0: value = 32'($urandom_range(262143)) - 32'sd131072;
            1: value = {2'b01, 30'($urandom)};
            2: value = {2'b10, 30'($urandom)};
            default: value = 32'($urandom);
         endcase
         send_triplet(OP_ADD, col, row, value);
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   endtask

   always @(posedge clock) begin
      outcome_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding, rsp_status %0d", rsp_status);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $error("rsp_status: expected %0d, got %0d", exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_slot !== exp_res.slot) begin
               $error("rsp_slot: expected %0d, got %0d", exp_res.slot, rsp_slot);
               error_count++;
            end
            if (rsp_entry_count !== exp_res.entry_count) begin
               $error("rsp_entry_count: expected %0d, got %0d",
                      exp_res.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_sum !== exp_res.sum) begin
               $error("rsp_sum: expected %0d, got %0d", exp_res.sum, rsp_sum);
               error_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 9;
      recv_idle_pct = 67;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_triplets(200);
      send_idle_pct = 67;
      recv_idle_pct = 9;
      test_random_triplets(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_triplets(180);
      finish_run();
   end

endmodule
